[design/i2cmrt_pkg.sv]
package i2cmrt_pkg;

	localparam int BUF_DEPTH = 32;
	localparam int BUF_AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

	localparam logic [7:0] ST_START      = 8'h08;
	localparam logic [7:0] ST_ADDR_W_ACK = 8'h18;
	localparam logic [7:0] ST_DATA_ACK   = 8'h28;
	localparam logic [7:0] ST_DATA_NACK  = 8'h30;
	localparam logic [7:0] ST_ADDR_R_ACK = 8'h40;
	localparam logic [7:0] ST_ADDR_R_NAK = 8'h48;

	typedef enum logic [1:0] {
		MODE_START  = 2'd0,
		MODE_STATUS = 2'd1,
		MODE_LOAD   = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ACK_NONE  = 2'd0,
		ACK_SET   = 2'd1,
		ACK_CLEAR = 2'd2
	} ack_t;

	typedef enum logic [1:0] {
		REG_DIRECTION   = 2'd0,
		REG_DEVICE_ADDR = 2'd1,
		REG_REGISTER    = 2'd2,
		REG_LENGTH      = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] status_code;
		logic [7:0] received_byte;
		logic [4:0] load_index;
		logic [7:0] load_byte;
	} in_item_t;

	typedef struct packed {
		logic       send_valid;
		logic [7:0] send_byte;
		logic       request_start;
		logic       request_stop;
		logic [1:0] ack_action;
		logic       store_valid;
		logic [4:0] store_index;
		logic [7:0] store_byte;
		logic       transfer_done;
	} out_item_t;

	typedef struct packed {
		logic [1:0] index;
		logic [7:0] wdata;
	} cfg_item_t;

	typedef struct packed {
		logic       direction;
		logic [7:0] device_addr_byte;
		logic [7:0] register_addr;
		logic [5:0] transfer_length;
	} cfg_t;

endpackage

[design/i2cmrt_in_if.sv]
interface i2cmrt_in_if;
	logic                 valid;
	logic                 ready;
	i2cmrt_pkg::in_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[design/i2cmrt_out_if.sv]
interface i2cmrt_out_if;
	logic                  valid;
	logic                  ready;
	i2cmrt_pkg::out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[design/i2cmrt_cfg_if.sv]
interface i2cmrt_cfg_if;
	logic                  valid;
	logic                  ready;
	i2cmrt_pkg::cfg_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[design/i2c_master_register_transfer.sv]
// channel   role    carries
// req       sink    start, status event or buffer load
// rsp       source  one decision per request
// cfg       sink    register index and write data
//
// a request is held in an input register and decided once the result register is free,
// where the result and the new sequencer state are registered together
// one request per cycle sustained while rsp is not stalled
// arst_n clears the valid bits, the sequencer state and the config registers;
// the write buffer is not cleared
// a stalled result holds; one more request waits in the input register
module i2c_master_register_transfer (
	input  logic         clk,
	input  logic         arst_n,
	i2cmrt_in_if.sink    req,
	i2cmrt_out_if.source rsp,
	i2cmrt_cfg_if.sink   cfg
);

	i2cmrt_pkg::in_item_t          item_s1;
	logic                          valid_s1;
	i2cmrt_pkg::out_item_t         out_q;
	logic                          out_valid_q;
	i2cmrt_pkg::out_item_t         result;
	i2cmrt_pkg::cfg_t              regs;
	logic                          advance;
	logic [i2cmrt_pkg::BUF_AW-1:0] rd_index;
	logic [7:0]                    rd_byte;

	assign advance     = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready   = !valid_s1 || advance;
	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

	i2cmrt_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	i2cmrt_wbuf u_wbuf (
		.clk      (clk),
		.wr_en    (advance && (item_s1.mode == i2cmrt_pkg::MODE_LOAD)),
		.wr_index (item_s1.load_index),
		.wr_byte  (item_s1.load_byte),
		.rd_index (rd_index),
		.rd_byte  (rd_byte)
	);

	i2cmrt_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (advance),
		.item     (item_s1),
		.regs     (regs),
		.rd_index (rd_index),
		.rd_byte  (rd_byte),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= req.payload;
		end
		if (advance) begin
			out_q <= result;
		end
	end

	a_advance_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp.valid)
		else $error("decided transaction did not reach the result register");

	a_empty_stage_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> req.ready)
		else $error("input stalled with an empty input register");

	a_send_store_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.payload.send_valid && rsp.payload.store_valid))
		else $error("send and store in one result");

	a_start_stop_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.payload.request_start && rsp.payload.request_stop))
		else $error("start and stop in one result");

	a_ack_clear_on_store: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.payload.ack_action == i2cmrt_pkg::ACK_CLEAR)
		|-> rsp.payload.store_valid)
		else $error("acknowledge cleared without a stored byte");

endmodule

[design/i2cmrt_cfg_regs.sv]
module i2cmrt_cfg_regs (
	input  logic                  clk,
	input  logic                  arst_n,
	i2cmrt_cfg_if.sink            cfg,
	output i2cmrt_pkg::cfg_t      regs
);

	i2cmrt_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (i2cmrt_pkg::reg_idx_t'(cfg.payload.index))
				i2cmrt_pkg::REG_DIRECTION:   regs_q.direction <= cfg.payload.wdata[0];
				i2cmrt_pkg::REG_DEVICE_ADDR: regs_q.device_addr_byte <= cfg.payload.wdata;
				i2cmrt_pkg::REG_REGISTER:    regs_q.register_addr <= cfg.payload.wdata;
				i2cmrt_pkg::REG_LENGTH:      regs_q.transfer_length <= cfg.payload.wdata[5:0];
				default: begin
				end
			endcase
		end
	end

endmodule

[design/i2cmrt_wbuf.sv]
module i2cmrt_wbuf (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [4:0]                    wr_index,
	input  logic [7:0]                    wr_byte,
	input  logic [i2cmrt_pkg::BUF_AW-1:0] rd_index,
	output logic [7:0]                    rd_byte
);

	logic [7:0] mem_q [i2cmrt_pkg::BUF_DEPTH];
	logic       in_range;

	// loads beyond the buffer are dropped
	assign in_range = {4'd0, wr_index} < 9'(i2cmrt_pkg::BUF_DEPTH);
	assign rd_byte  = mem_q[rd_index];

	always_ff @(posedge clk) begin
		if (wr_en && in_range) begin
			mem_q[i2cmrt_pkg::BUF_AW'(wr_index)] <= wr_byte;
		end
	end

endmodule

[design/i2cmrt_seq.sv]
module i2cmrt_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  i2cmrt_pkg::in_item_t          item,
	input  i2cmrt_pkg::cfg_t              regs,
	output logic [i2cmrt_pkg::BUF_AW-1:0] rd_index,
	input  logic [7:0]                    rd_byte,
	output i2cmrt_pkg::out_item_t         result
);

	logic [5:0] byte_index_q;
	logic       read_phase_q;
	logic       done_q;
	logic [5:0] byte_index_d;
	logic       read_phase_d;
	logic       done_d;
	logic [5:0] index_inc;
	logic       at_end;
	logic       in_buf;

	assign rd_index  = i2cmrt_pkg::BUF_AW'(byte_index_q);
	assign index_inc = byte_index_q + 6'd1;
	assign at_end    = byte_index_q >= regs.transfer_length;
	assign in_buf    = {3'd0, byte_index_q} < 9'(i2cmrt_pkg::BUF_DEPTH);

	always_comb begin
		byte_index_d = byte_index_q;
		read_phase_d = read_phase_q;
		done_d       = done_q;
		result       = '0;
		case (item.mode)
			i2cmrt_pkg::MODE_START: begin
				done_d               = 1'b0;
				read_phase_d         = 1'b0;
				result.request_start = 1'b1;
			end
			i2cmrt_pkg::MODE_STATUS: begin
				if (!regs.direction) begin
					case (item.status_code)
						i2cmrt_pkg::ST_START: begin
							result.send_valid = 1'b1;
							result.send_byte  = regs.device_addr_byte;
						end
						i2cmrt_pkg::ST_ADDR_W_ACK: begin
							result.send_valid = 1'b1;
							result.send_byte  = regs.register_addr;
							byte_index_d      = '0;
						end
						i2cmrt_pkg::ST_DATA_ACK: begin
							if (at_end) begin
								result.request_stop = 1'b1;
								done_d              = 1'b1;
							end else begin
								result.send_valid = 1'b1;
								result.send_byte  = in_buf ? rd_byte : 8'd0;
								byte_index_d      = index_inc;
							end
						end
						default: begin
						end
					endcase
				end else begin
					case (item.status_code)
						i2cmrt_pkg::ST_START: begin
							result.send_valid = 1'b1;
							result.send_byte  = {regs.device_addr_byte[7:1],
								regs.device_addr_byte[0] | read_phase_q};
						end
						i2cmrt_pkg::ST_ADDR_W_ACK: begin
							result.send_valid = 1'b1;
							result.send_byte  = regs.register_addr;
						end
						i2cmrt_pkg::ST_DATA_ACK: begin
							if (!read_phase_q) begin
								result.request_start = 1'b1;
								read_phase_d         = 1'b1;
							end else if (at_end) begin
								result.request_stop = 1'b1;
								done_d              = 1'b1;
							end else begin
								result.store_valid = 1'b1;
								result.store_index = byte_index_q[4:0];
								result.store_byte  = item.received_byte;
								byte_index_d       = index_inc;
								result.ack_action  = (index_inc < regs.transfer_length) ?
									i2cmrt_pkg::ACK_SET : i2cmrt_pkg::ACK_CLEAR;
							end
						end
						i2cmrt_pkg::ST_DATA_NACK: begin
							if (read_phase_q && at_end) begin
								result.request_stop = 1'b1;
								done_d              = 1'b1;
							end
						end
						i2cmrt_pkg::ST_ADDR_R_ACK, i2cmrt_pkg::ST_ADDR_R_NAK: begin
							result.ack_action = i2cmrt_pkg::ACK_SET;
							byte_index_d      = '0;
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
			end
		endcase
		result.transfer_done = done_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q <= '0;
			read_phase_q <= 1'b0;
			done_q       <= 1'b0;
		end else if (fire) begin
			byte_index_q <= byte_index_d;
			read_phase_q <= read_phase_d;
			done_q       <= done_d;
		end
	end

endmodule

[test/i2cmrt_check_pkg.sv]
`timescale 1ns / 100ps

package i2cmrt_check_pkg;

	import i2cmrt_pkg::*;

	class decision_checker;
		logic       dir;
		logic [7:0] dev_addr;
		logic [7:0] reg_addr;
		logic [5:0] xfer_len;
		logic [5:0] byte_pos;
		logic       reading;
		logic       done;
		logic [7:0] tx_buffer [BUF_DEPTH];
		out_item_t  due_decisions [$];
		int         errors;

		function new();
			dir      = 1'b0;
			dev_addr = '0;
			reg_addr = '0;
			xfer_len = '0;
			byte_pos = '0;
			reading  = 1'b0;
			done     = 1'b0;
			errors   = 0;
			foreach (tx_buffer[i]) tx_buffer[i] = '0;
		endfunction

		function void write_reg(cfg_item_t w);
			case (w.index)
				REG_DIRECTION:   dir = w.wdata[0];
				REG_DEVICE_ADDR: dev_addr = w.wdata;
				REG_REGISTER:    reg_addr = w.wdata;
				REG_LENGTH:      xfer_len = w.wdata[5:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return due_decisions.size();
		endfunction

		// work out the decision for one accepted transaction
		function void note_request(in_item_t it);
			out_item_t d;
			d = '0;
			case (it.mode)
				MODE_START: begin
					done = 1'b0;
					reading = 1'b0;
					d.request_start = 1'b1;
				end
				MODE_LOAD: begin
					tx_buffer[it.load_index] = it.load_byte;
				end
				MODE_STATUS: begin
					if (!dir) begin
						case (it.status_code)
							ST_START: begin
								d.send_valid = 1'b1;
								d.send_byte = dev_addr;
							end
							ST_ADDR_W_ACK: begin
								d.send_valid = 1'b1;
								d.send_byte = reg_addr;
								byte_pos = '0;
							end
							ST_DATA_ACK: begin
								if (byte_pos >= xfer_len) begin
									d.request_stop = 1'b1;
									done = 1'b1;
								end else begin
									d.send_valid = 1'b1;
									d.send_byte = (byte_pos < BUF_DEPTH) ?
										tx_buffer[BUF_AW'(byte_pos)] : 8'h00;
									byte_pos = byte_pos + 6'd1;
								end
							end
							default: ;
						endcase
					end else begin
						case (it.status_code)
							ST_START: begin
								d.send_valid = 1'b1;
								d.send_byte = reading ? (dev_addr | 8'h01) : dev_addr;
							end
							ST_ADDR_W_ACK: begin
								d.send_valid = 1'b1;
								d.send_byte = reg_addr;
							end
							ST_DATA_ACK: begin
								if (!reading) begin
									d.request_start = 1'b1;
									reading = 1'b1;
								end else if (byte_pos >= xfer_len) begin
									d.request_stop = 1'b1;
									done = 1'b1;
								end else begin
									d.store_valid = 1'b1;
									d.store_index = byte_pos[4:0];
									d.store_byte = it.received_byte;
									byte_pos = byte_pos + 6'd1;
									d.ack_action = (byte_pos < xfer_len) ? ACK_SET : ACK_CLEAR;
								end
							end
							ST_DATA_NACK: begin
								if (reading && byte_pos >= xfer_len) begin
									d.request_stop = 1'b1;
									done = 1'b1;
								end
							end
							ST_ADDR_R_ACK, ST_ADDR_R_NAK: begin
								d.ack_action = ACK_SET;
								byte_pos = '0;
							end
							default: ;
						endcase
					end
				end
				default: ;
			endcase
			d.transfer_done = done;
			due_decisions.push_back(d);
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task compare_field(string name, logic [7:0] got, logic [7:0] want);
			if (got !== want)
				report($sformatf("%s got %0h expected %0h", name, got, want));
		endtask

		task check_decision(out_item_t got);
			out_item_t want;
			if (due_decisions.size() == 0) begin
				report($sformatf("result %h with no transaction waiting", got));
				return;
			end
			want = due_decisions.pop_front();
			compare_field("send_valid", 8'(got.send_valid), 8'(want.send_valid));
			compare_field("send_byte", got.send_byte, want.send_byte);
			compare_field("request_start", 8'(got.request_start), 8'(want.request_start));
			compare_field("request_stop", 8'(got.request_stop), 8'(want.request_stop));
			compare_field("ack_action", 8'(got.ack_action), 8'(want.ack_action));
			compare_field("store_valid", 8'(got.store_valid), 8'(want.store_valid));
			compare_field("store_index", 8'(got.store_index), 8'(want.store_index));
			compare_field("store_byte", got.store_byte, want.store_byte);
			compare_field("transfer_done", 8'(got.transfer_done), 8'(want.transfer_done));
		endtask
	endclass

endpackage

[test/tb.sv]
`timescale 1ns / 100ps

module tb;

	import i2cmrt_pkg::*;
	import i2cmrt_check_pkg::*;

	localparam int         STALL_LIMIT = 2000;
	localparam int         ITEM_TARGET = 1400;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	logic clk;
	logic arst_n;

	i2cmrt_in_if  req();
	i2cmrt_out_if rsp();
	i2cmrt_cfg_if cfg();

	decision_checker board;
	int              sent = 0;
	int              quiet_cycles = 0;
	bit              steady = 1'b0;
	bit [31:0]       loaded = '0;
	logic            cur_dir = 1'b0;
	int              cur_len = 0;
	logic [7:0]      known_codes [6] = '{ST_START, ST_ADDR_W_ACK, ST_DATA_ACK,
		ST_DATA_NACK, ST_ADDR_R_ACK, ST_ADDR_R_NAK};

	i2c_master_register_transfer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(negedge clk) begin
		rsp.ready <= steady || ($urandom_range(0, 99) >= 11);
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			board.check_decision(rsp.payload);
	end

	// watchdog on cycles with no transaction on any channel
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic in_item_t filler();
		in_item_t it;
		it.mode          = MODE_UNUSED;
		it.status_code   = 8'($urandom_range(0, 255));
		it.received_byte = 8'($urandom_range(0, 255));
		it.load_index    = 5'($urandom_range(0, 31));
		it.load_byte     = 8'($urandom_range(0, 255));
		return it;
	endfunction

	task automatic push(input in_item_t it);
		while (!steady && $urandom_range(0, 99) < 11) begin
			@(negedge clk);
			req.valid <= 1'b0;
		end
		@(negedge clk);
		req.valid   <= 1'b1;
		req.payload <= it;
		do @(posedge clk); while (req.ready !== 1'b1);
		board.note_request(it);
		if (it.mode != MODE_UNUSED)
			sent++;
	endtask

	task automatic begin_transfer();
		in_item_t it;
		it = filler();
		it.mode = MODE_START;
		push(it);
	endtask

	task automatic status(input logic [7:0] code);
		in_item_t it;
		it = filler();
		it.mode = MODE_STATUS;
		it.status_code = code;
		push(it);
	endtask

	task automatic load(input logic [4:0] idx, input logic [7:0] data);
		in_item_t it;
		it = filler();
		it.mode = MODE_LOAD;
		it.load_index = idx;
		it.load_byte = data;
		push(it);
		loaded[idx] = 1'b1;
	endtask

	task automatic noise();
		in_item_t it;
		it = filler();
		it.mode = 2'($urandom_range(0, 3));
		if ($urandom_range(0, 1) == 0)
			it.status_code = known_codes[3'($urandom_range(0, 5))];
		push(it);
	endtask

	// hold the sender until every decision has come back
	task automatic drain();
		@(negedge clk);
		req.valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [7:0] data);
		cfg_item_t w;
		w.index = idx;
		w.wdata = data;
		@(negedge clk);
		cfg.valid   <= 1'b1;
		cfg.payload <= w;
		do @(posedge clk); while (cfg.ready !== 1'b1);
		board.write_reg(w);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic configure(input logic dir, input logic [7:0] dev, input logic [7:0] regaddr,
		input int len);
		drain();
		write_reg(REG_DIRECTION, {7'd0, dir});
		write_reg(REG_DEVICE_ADDR, dev);
		write_reg(REG_REGISTER, regaddr);
		write_reg(REG_LENGTH, len[7:0]);
		cur_dir = dir;
		cur_len = len;
		// every entry a write transfer can reach holds data
		for (int i = 0; i < len; i++)
			if (!loaded[i]) load(5'(i), 8'($urandom_range(0, 255)));
	endtask

	task automatic write_transfer(input bit broken);
		int steps;
		int cut;
		steps = cur_len + 4;
		cut = broken ? $urandom_range(0, steps - 1) : steps;
		for (int s = 0; s < cut; s++) begin
			if (s == 0) begin_transfer();
			else if (s == 1) status(ST_START);
			else if (s == 2) status(ST_ADDR_W_ACK);
			else status(ST_DATA_ACK);
			if ($urandom_range(0, 19) == 0)
				load(5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
		end
		if (broken)
			noise();
	endtask

	task automatic read_transfer(input bit broken);
		int steps;
		int cut;
		steps = cur_len + 7;
		cut = broken ? $urandom_range(0, steps - 1) : steps;
		for (int s = 0; s < cut; s++) begin
			if (s == 0) begin_transfer();
			else if (s == 1 || s == 4) status(ST_START);
			else if (s == 2) status(ST_ADDR_W_ACK);
			else if (s == 3) status(ST_DATA_ACK);
			else if (s == 5) status($urandom_range(0, 1) ? ST_ADDR_R_ACK : ST_ADDR_R_NAK);
			else if (s < steps - 1) status(ST_DATA_ACK);
			else status($urandom_range(0, 1) ? ST_DATA_ACK : ST_DATA_NACK);
		end
		if (broken)
			noise();
	endtask

	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(0, 3);
		if (r == 0) return 8'h00;
		if (r == 1) return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	initial begin
		int r;
		int phase_left;
		int len;
		phase_left = 0;
		board = new();
		arst_n      = 1'b0;
		req.valid   = 1'b0;
		req.payload = '0;
		cfg.valid   = 1'b0;
		cfg.payload = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: empty write transfer
		write_transfer(1'b0);
		load(5'd0, 8'h00);
		load(5'd1, 8'hFF);
		load(5'd31, 8'hFF);
		configure(1'b0, 8'hFF, 8'h00, 2);
		write_transfer(1'b0);
		noise();
		status(8'hFF);
		configure(1'b1, 8'h00, 8'hFF, 1);
		read_transfer(1'b0);
		status(ST_DATA_NACK);

		while (sent < ITEM_TARGET) begin
			steady = (sent >= 600 && sent < 800);
			if (phase_left == 0) begin
				r = $urandom_range(0, 9);
				len = (r == 0) ? 32 : (r == 1) ? 0 : $urandom_range(1, 8);
				configure(1'($urandom_range(0, 1)), pick_byte(), pick_byte(), len);
				phase_left = $urandom_range(2, 6);
			end
			r = $urandom_range(0, 99);
			if (r < 70) begin
				if (cur_dir) read_transfer(1'b0);
				else write_transfer(1'b0);
			end else if (r < 85) begin
				if (cur_dir) read_transfer(1'b1);
				else write_transfer(1'b1);
			end else begin
				repeat ($urandom_range(1, 5)) noise();
			end
			if ($urandom_range(0, 24) == 0)
				drain();
			phase_left--;
		end
		steady = 1'b0;

		drain();
		repeat (10) @(posedge clk);
		if (board.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
